/* rtl/tpe_pkg.sv */
package tpe_pkg;

  localparam int SEGMENT_BYTES = 256;
  localparam int SEG_CNT_W     = $clog2(SEGMENT_BYTES + 1);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [7:0]  SILENCE_LEVEL = 8'd128;

  typedef enum logic [1:0] {
    CMD_PLAIN   = 2'd0,
    CMD_SYNC    = 2'd1,
    CMD_SEGMENT = 2'd2,
    CMD_SILENCE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_LOW_LEVEL  = 2'd0,
    REG_HIGH_LEVEL = 2'd1,
    REG_ZERO_WIDTH = 2'd2,
    REG_ONE_WIDTH  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    JOB_BYTE    = 2'd0,
    JOB_SYNC    = 2'd1,
    JOB_SILENCE = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  data;
    logic        with_crc;
    logic [15:0] crc_fin;
    logic [17:0] slen;
  } job_t;

  typedef struct packed {
    logic [6:0] low_level;
    logic [7:0] high_level;
    logic [3:0] zero_width;
    logic [3:0] one_width;
  } cfg_t;

endpackage

/* rtl/tpe_front.sv */
module tpe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_data_byte,
  input  logic [17:0]         in_silence_length,
  input  logic                q_full,
  output logic                q_push,
  output tpe_pkg::job_t       q_job
);

  logic [15:0]                    crc_r, crc_nxt;
  logic [tpe_pkg::SEG_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [tpe_pkg::SEG_CNT_W-1:0]  cnt_inc;
  logic [15:0]                    crc_upd;
  logic                           accept;
  logic                           seg_end;
  tpe_pkg::cmd_t                  cmd;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (acc[15]) acc = {acc[14:0], 1'b0} ^ tpe_pkg::CRC_POLY;
      else         acc = {acc[14:0], 1'b0};
    end
    return acc;
  endfunction

  assign cmd      = tpe_pkg::cmd_t'(in_command);
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign crc_upd  = crc_byte(crc_r, in_data_byte);
  assign cnt_inc  = cnt_r + 1'b1;
  assign seg_end  = (cnt_inc >= tpe_pkg::SEG_CNT_W'(tpe_pkg::SEGMENT_BYTES));

  always_comb begin
    q_job          = '0;
    q_job.data     = in_data_byte;
    q_job.slen     = in_silence_length;
    q_job.crc_fin  = ~crc_upd;
    q_push         = accept;
    crc_nxt        = crc_r;
    cnt_nxt        = cnt_r;
    unique case (cmd)
      tpe_pkg::CMD_PLAIN: q_job.kind = tpe_pkg::JOB_BYTE;
      tpe_pkg::CMD_SYNC:  q_job.kind = tpe_pkg::JOB_SYNC;
      tpe_pkg::CMD_SEGMENT: begin
        q_job.kind     = tpe_pkg::JOB_BYTE;
        q_job.with_crc = seg_end;
        if (accept) begin
          crc_nxt = seg_end ? tpe_pkg::CRC_INIT : crc_upd;
          cnt_nxt = seg_end ? '0 : cnt_inc;
        end
      end
      default: begin
        q_job.kind = tpe_pkg::JOB_SILENCE;
        // empty silence makes no runs
        q_push     = accept && (in_silence_length != '0);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= tpe_pkg::CRC_INIT;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/tpe_queue.sv */
module tpe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tpe_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tpe_pkg::job_t  head
);

  tpe_pkg::job_t                   mem_r [tpe_pkg::QUEUE_DEPTH];
  logic [tpe_pkg::QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [tpe_pkg::QUEUE_PTR_W:0]   count_r;
  logic                            do_push, do_pop;

  assign full    = (count_r == (tpe_pkg::QUEUE_PTR_W+1)'(tpe_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/tpe_back.sv */
module tpe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tpe_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  tpe_pkg::job_t  q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_sample_value,
  output logic [17:0]    out_run_length,
  output logic           out_last
);

  logic [5:0]  idx_r;
  logic        out_valid_r;
  logic [7:0]  level_r;
  logic [17:0] len_r;
  logic        last_r;

  logic        advance;
  logic        run_last;
  logic [7:0]  cur_byte;
  logic        cur_bit;
  logic [3:0]  bit_w;
  logic [7:0]  bit_level;
  logic [7:0]  level_nxt;
  logic [17:0] len_nxt;

  assign advance = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop   = advance && run_last;

  always_comb begin
    unique case (idx_r[5:4])
      2'd1:    cur_byte = q_head.crc_fin[15:8];
      2'd2:    cur_byte = q_head.crc_fin[7:0];
      default: cur_byte = q_head.data;
    endcase
    // MSB first: bit 7 at runs 0 and 1
    cur_bit   = (q_head.kind == tpe_pkg::JOB_BYTE) ? cur_byte[~idx_r[3:1]] : 1'b0;
    bit_w     = cur_bit ? cfg.one_width : cfg.zero_width;
    if (bit_w == '0) bit_w = 4'd1;
    bit_level = idx_r[0] ? cfg.high_level : {1'b0, cfg.low_level};

    unique case (q_head.kind)
      tpe_pkg::JOB_BYTE: begin
        run_last  = q_head.with_crc ? (idx_r == 6'd47) : (idx_r == 6'd15);
        level_nxt = bit_level;
        len_nxt   = 18'(bit_w);
      end
      tpe_pkg::JOB_SYNC: begin
        run_last  = (idx_r == 6'd1);
        level_nxt = bit_level;
        len_nxt   = 18'(bit_w);
      end
      default: begin
        run_last  = 1'b1;
        level_nxt = tpe_pkg::SILENCE_LEVEL;
        len_nxt   = q_head.slen;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level_r <= level_nxt;
      len_r   <= len_nxt;
      last_r  <= run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      idx_r       <= run_last ? '0 : idx_r + 1'b1;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = level_r;
  assign out_run_length   = len_r;
  assign out_last         = last_r;

endmodule

/* rtl/tape_pulse_encoder_with_crc16_top.sv */
// An accepted item is queued; the serializer then registers its runs at the output.
// Throughput: one run per cycle when not stalled; each bit is a low then a high run,
// a segment-closing byte adds its two CRC bytes, silence is one run (run serializer).
// A 4-word queue sits between command decode/CRC and the serializer.
// Reset (rst_n low, synchronous): registers back to defaults, CRC 0xFFFF,
// segment count 0, queue and output empty.
module tape_pulse_encoder_with_crc16_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic [17:0] in_silence_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_sample_value,
  output logic [17:0] out_run_length,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  tpe_pkg::cfg_t cfg_r;
  tpe_pkg::job_t push_job, head_job;
  logic          q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_level  <= 7'd32;
      cfg_r.high_level <= 8'd224;
      cfg_r.zero_width <= 4'd1;
      cfg_r.one_width  <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tpe_pkg::reg_idx_t'(cfg_index))
        tpe_pkg::REG_LOW_LEVEL:  cfg_r.low_level  <= cfg_data[6:0];
        tpe_pkg::REG_HIGH_LEVEL: cfg_r.high_level <= cfg_data;
        tpe_pkg::REG_ZERO_WIDTH: cfg_r.zero_width <= cfg_data[3:0];
        default:                 cfg_r.one_width  <= cfg_data[3:0];
      endcase
    end
  end

  tpe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_data_byte      (in_data_byte),
    .in_silence_length (in_silence_length),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (push_job)
  );

  tpe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  tpe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_head           (head_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_run_length   (out_run_length),
    .out_last         (out_last)
  );

endmodule

/* rtl/tpe_checker.sv */
module tpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_sample_value,
  input logic [17:0] out_run_length,
  input logic        out_last
);

  // nothing is on the output right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // only silence runs can exceed the 4-bit bit width
  a_long_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_run_length > 18'd15) |-> out_last && (out_sample_value == 8'd128))
    else $error("long run that is not silence");

  // widths clamp to one and empty silence is dropped
  a_no_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_length != 18'd0))
    else $error("run of zero length");

  a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_stall))
    else $error("input stall unknown");

endmodule

bind tape_pulse_encoder_with_crc16_top tpe_checker u_tpe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample_value (out_sample_value),
  .out_run_length   (out_run_length),
  .out_last         (out_last)
);
